>>> design/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked at every rising edge, also during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");

// Checked only while reset is low.
`define ASSERT_RUN(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, prop)
`define ASSERT_RUN(lbl, clk, rst, prop)

`endif

`endif

>>> design/sigd_pkg.sv
package sigd_pkg;

  localparam int IN_WIDTH     = 12;
  localparam int IN_FRAC_BITS = 8;
  localparam int OUT_WIDTH    = 16;

  // |x| reaches 2^(IN_WIDTH-1), so the lookup holds one entry more than half the codes
  localparam int ROM_DEPTH = (1 << (IN_WIDTH - 1)) + 1;
  localparam int MAG_W     = $clog2(ROM_DEPTH);

  localparam int S_TDATA_W = ((IN_WIDTH + 7) / 8) * 8;
  localparam int M_TDATA_W = ((OUT_WIDTH + 7) / 8) * 8;

  localparam int PROD_W = 2 * OUT_WIDTH + 1;

  localparam logic [OUT_WIDTH:0]     FULL     = (OUT_WIDTH + 1)'(1) << OUT_WIDTH;
  localparam logic [OUT_WIDTH-1:0]   HALF_MAX = OUT_WIDTH'(1) << (OUT_WIDTH - 1);

  // Q2.62 internal format used to build the lookup
  localparam logic [63:0] QONE           = 64'h4000_0000_0000_0000;
  localparam int          SERIES_TERMS   = 30;
  localparam int          EXP_ZERO_LIMIT = 45;

  typedef struct packed {
    logic func;
    logic neg;
  } sigd_ctl_t;

  typedef logic [OUT_WIDTH-1:0] half_rom_t [ROM_DEPTH];

  // floor(a * b / 2^62)
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // exp(-r), alternating series, truncated products
  function automatic logic [63:0] exp_neg_q62(input logic [63:0] r);
    logic [63:0] term;
    logic [63:0] sum;
    term = QONE;
    sum  = QONE;
    for (int k = 1; k <= SERIES_TERMS; k++) begin
      term = mul_q62(term, r) / 64'(k);
      if ((k % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // round(2^OUT_WIDTH * sigmoid(-mag))
  function automatic logic [OUT_WIDTH-1:0] sigmoid_half(input logic [63:0] mag,
                                                        input logic [63:0] einv);
    logic [63:0] ipart;
    logic [63:0] fpart;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] half;
    ipart = mag >> IN_FRAC_BITS;
    fpart = (mag & ((64'd1 << IN_FRAC_BITS) - 64'd1)) << (62 - IN_FRAC_BITS);
    if (ipart >= 64'(EXP_ZERO_LIMIT)) begin
      e = 64'd0;
    end else begin
      e = exp_neg_q62(fpart);
      for (longint unsigned n = 0; n < ipart; n++) begin
        e = mul_q62(e, einv);
      end
    end
    d   = QONE + e;
    rem = e;
    quo = 64'd0;
    for (int i = 0; i < OUT_WIDTH + 1; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= d) begin
        rem = rem - d;
        quo = quo | 64'd1;
      end
    end
    half = (quo + 64'd1) >> 1;
    return half[OUT_WIDTH-1:0];
  endfunction

  function automatic half_rom_t build_half_rom();
    half_rom_t   t;
    logic [63:0] einv;
    einv = exp_neg_q62(QONE);
    for (int i = 0; i < ROM_DEPTH; i++) begin
      t[i] = sigmoid_half(64'(i), einv);
    end
    return t;
  endfunction

endpackage

>>> design/sigd_abs.sv
module sigd_abs import sigd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_func,
  input  logic [IN_WIDTH-1:0]  in_x,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sigd_ctl_t            out_ctl,
  output logic [MAG_W-1:0]     out_mag
);

  logic              neg;
  logic [MAG_W-1:0]  mag_next;

  assign neg      = in_x[IN_WIDTH-1];
  // -(-2^(IN_WIDTH-1)) stays correct read as unsigned
  assign mag_next = neg ? MAG_W'(-in_x) : MAG_W'(in_x);
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_ctl.func <= in_func;
      out_ctl.neg  <= neg;
      out_mag      <= mag_next;
    end
  end

endmodule

>>> design/sigd_rom.sv
module sigd_rom import sigd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sigd_ctl_t             in_ctl,
  input  logic [MAG_W-1:0]      in_mag,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sigd_ctl_t             out_ctl,
  output logic [OUT_WIDTH-1:0]  out_half
);

  // sigmoid(-|x|) per magnitude, built at elaboration
  localparam half_rom_t HALF_ROM = build_half_rom();

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_ctl  <= in_ctl;
      out_half <= HALF_ROM[in_mag];
    end
  end

endmodule

>>> design/sigd_post.sv
module sigd_post import sigd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sigd_ctl_t             in_ctl,
  input  logic [OUT_WIDTH-1:0]  in_half,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_WIDTH-1:0]  out_y
);

  localparam logic [PROD_W-1:0] RND = PROD_W'(1) << (OUT_WIDTH - 1);

  // stage C: fold sign back, saturate
  logic                  c_valid;
  logic                  c_func;
  logic [OUT_WIDTH-1:0]  c_s;
  logic                  c_ready;
  logic [OUT_WIDTH:0]    upper;
  logic [OUT_WIDTH-1:0]  s_next;

  // stage D: s * (1 - s)
  logic                  d_valid;
  logic                  d_func;
  logic [OUT_WIDTH-1:0]  d_s;
  logic [PROD_W-1:0]     d_prod;
  logic                  d_ready;
  logic [OUT_WIDTH:0]    comp;

  // stage E: round, output register
  logic                  e_ready;
  logic [PROD_W-1:0]     rnd_sum;
  logic [OUT_WIDTH-1:0]  y_next;

  assign upper  = FULL - {1'b0, in_half};
  assign s_next = in_ctl.neg ? in_half :
                  (upper[OUT_WIDTH] ? {OUT_WIDTH{1'b1}} : upper[OUT_WIDTH-1:0]);

  assign comp    = FULL - {1'b0, c_s};
  assign rnd_sum = d_prod + RND;
  assign y_next  = d_func ? rnd_sum[OUT_WIDTH +: OUT_WIDTH] : d_s;

  assign e_ready  = !out_valid || out_ready;
  assign d_ready  = !d_valid || e_ready;
  assign c_ready  = !c_valid || d_ready;
  assign in_ready = c_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (c_ready) begin
        c_valid <= in_valid;
      end
      if (d_ready) begin
        d_valid <= c_valid;
      end
      if (e_ready) begin
        out_valid <= d_valid;
      end
    end
    if (c_ready && in_valid) begin
      c_func <= in_ctl.func;
      c_s    <= s_next;
    end
    if (d_ready && c_valid) begin
      d_func <= c_func;
      d_s    <= c_s;
      d_prod <= PROD_W'(c_s) * PROD_W'(comp);
    end
    if (e_ready && d_valid) begin
      out_y <= y_next;
    end
  end

endmodule

>>> design/sigmoid_and_derivative_unit.sv
// channel  dir  tdata (low bit up)         tuser
// s        in   x[11:0], zero pad to 16    func (0 sigmoid, 1 derivative)
// m        out  y[15:0]                    -
//
// One request per cycle sustained while m_tready is held high; an accepted
// request passes through each stage register below, in order, before m_tvalid rises.
// The 5 stages: magnitude, lookup ROM registered read, sign fold/saturate,
// 16x17 derivative multiply, rounding into the output register.
// rst is synchronous, active high, and clears only the stage valid bits;
// the lookup is a constant ROM, so no clearing pass follows reset.
// Each stage holds its request while the next one is full and stalled, so
// bubbles are squeezed out and a stall drops or repeats nothing.
`include "assert_macros.svh"

module sigmoid_and_derivative_unit import sigd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // x
  input  logic                  s_tuser,   // func
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata    // y
);

  // magnitude stage -> lookup stage
  logic                  abs_valid;
  logic                  abs_ready;
  sigd_ctl_t             abs_ctl;
  logic [MAG_W-1:0]      abs_mag;

  // lookup stage -> post stages
  logic                  rom_valid;
  logic                  rom_ready;
  sigd_ctl_t             rom_ctl;
  logic [OUT_WIDTH-1:0]  rom_half;

  logic [OUT_WIDTH-1:0]  y;

  sigd_abs u_abs (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_func   (s_tuser),
    .in_x      (s_tdata[IN_WIDTH-1:0]),
    .out_valid (abs_valid),
    .out_ready (abs_ready),
    .out_ctl   (abs_ctl),
    .out_mag   (abs_mag)
  );

  sigd_rom u_rom (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (abs_valid),
    .in_ready  (abs_ready),
    .in_ctl    (abs_ctl),
    .in_mag    (abs_mag),
    .out_valid (rom_valid),
    .out_ready (rom_ready),
    .out_ctl   (rom_ctl),
    .out_half  (rom_half)
  );

  sigd_post u_post (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rom_valid),
    .in_ready  (rom_ready),
    .in_ctl    (rom_ctl),
    .in_half   (rom_half),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_y     (y)
  );

  assign m_tdata = M_TDATA_W'(y);

  // a ready sink never stalls the source
  `ASSERT_ALWAYS(a_ready_chain, clk, m_tready |-> s_tready)
  // sigmoid(-|x|) never exceeds one half
  `ASSERT_RUN(a_half_range, clk, rst, rom_valid |-> (rom_half <= HALF_MAX))
  // a lookup entry holds while the post stage cannot take it
  `ASSERT_RUN(a_rom_hold, clk, rst,
    (rom_valid && !rom_ready) |=> (rom_valid && $stable(rom_half) && $stable(rom_ctl)))
  // pipeline empty right after reset
  `ASSERT_RUN(a_reset_empty, clk, rst, $past(rst) |-> (!m_tvalid && !rom_valid && !abs_valid))

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb import sigd_pkg::*; ();

  localparam int          CYCLE_LIMIT = 200000;
  localparam int          DRAIN_WAIT  = 20;
  localparam int          RAND_ITEMS  = 1000;
  // no idling on either side inside this cycle window
  localparam int          CALM_FROM   = 400;
  localparam int          CALM_TO     = 800;
  localparam logic [63:0] Q62_ONE     = 64'd1 << 62;
  localparam int          TAYLOR_N    = 30;
  localparam int          EXP_FLUSH   = 45;

  typedef enum logic { FN_SIGMOID = 1'b0, FN_DERIV = 1'b1 } fn_t;

  typedef struct {
    fn_t                   fn;
    logic [IN_WIDTH-1:0]   x;
  } sample_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata  = '0;
  logic                  s_tuser  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;

  sample_t               sample_q[$];
  logic [OUT_WIDTH-1:0]  y_expect_q[$];
  int                    cycle_cnt = 0;
  int                    err_cnt   = 0;

  sigmoid_and_derivative_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------
  // Expected-value computation, Q2.62 fixed point throughout
  // ---------------------------------------------------------------
  function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] wide;
    wide = 128'(a) * 128'(b);
    wide = wide >> 62;
    return wide[63:0];
  endfunction

  // exp(-r) by alternating Taylor series, each term truncated
  function automatic logic [63:0] exp_neg_fix(input logic [63:0] r);
    logic [63:0] term;
    logic [63:0] acc;
    term = Q62_ONE;
    acc  = Q62_ONE;
    for (int k = 1; k <= TAYLOR_N; k++) begin
      term = q62_product(term, r) / 64'(k);
      if (k % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    return acc;
  endfunction

  function automatic logic [OUT_WIDTH-1:0] sigmoid_fix(input logic [IN_WIDTH-1:0] x);
    logic [63:0]  mag;
    logic [63:0]  whole;
    logic [63:0]  frac;
    logic [63:0]  e;
    logic [63:0]  inv_e;
    logic [127:0] quo;
    logic [63:0]  lo_side;
    logic [63:0]  y;
    logic         neg;
    neg = x[IN_WIDTH-1];
    mag = neg ? ((64'd1 << IN_WIDTH) - 64'(x)) : 64'(x);
    whole = mag >> IN_FRAC_BITS;
    frac  = (mag & ((64'd1 << IN_FRAC_BITS) - 64'd1)) << (62 - IN_FRAC_BITS);
    if (whole >= 64'(EXP_FLUSH)) begin
      e = 64'd0;
    end else begin
      inv_e = exp_neg_fix(Q62_ONE);
      e     = exp_neg_fix(frac);
      for (int n = 0; n < int'(whole); n++) begin
        e = q62_product(e, inv_e);
      end
    end
    // sigmoid(-|x|) with one extra bit, then round half up
    quo     = (128'(e) << (OUT_WIDTH + 1)) / 128'(Q62_ONE + e);
    lo_side = (quo[63:0] + 64'd1) >> 1;
    y = neg ? lo_side : ((64'd1 << OUT_WIDTH) - lo_side);
    if (y > (64'd1 << OUT_WIDTH) - 64'd1) begin
      y = (64'd1 << OUT_WIDTH) - 64'd1;
    end
    return y[OUT_WIDTH-1:0];
  endfunction

  function automatic logic [OUT_WIDTH-1:0] logistic_result(input fn_t fn,
                                                           input logic [IN_WIDTH-1:0] x);
    logic [OUT_WIDTH-1:0]   s;
    logic [2*OUT_WIDTH+1:0] p;
    s = sigmoid_fix(x);
    if (fn == FN_SIGMOID) begin
      return s;
    end
    p = (2*OUT_WIDTH+2)'(s) * ((2*OUT_WIDTH+2)'(1) << OUT_WIDTH) -
        (2*OUT_WIDTH+2)'(s) * (2*OUT_WIDTH+2)'(s);
    p = (p + ((2*OUT_WIDTH+2)'(1) << (OUT_WIDTH - 1))) >> OUT_WIDTH;
    return p[OUT_WIDTH-1:0];
  endfunction

  function automatic logic want_idle();
    if (cycle_cnt >= CALM_FROM && cycle_cnt < CALM_TO) begin
      return 1'b0;
    end
    return $urandom_range(99) < 16;
  endfunction

  // ---------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------
  always @(posedge clk) begin : drive
    sample_t req;
    logic    holding;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      holding = s_tvalid;
      if (s_tvalid && s_tready) begin
        y_expect_q.push_back(logistic_result(fn_t'(s_tuser), s_tdata[IN_WIDTH-1:0]));
        holding = 1'b0;
      end
      if (!holding) begin
        if (sample_q.size() != 0 && !want_idle()) begin
          req = sample_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= S_TDATA_W'(req.x);
          s_tuser  <= req.fn;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Result monitor and output stall
  // ---------------------------------------------------------------
  always @(posedge clk) begin : watch
    logic [OUT_WIDTH-1:0] want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (y_expect_q.size() == 0) begin
          $error("y: expected none, actual %0d", m_tdata[OUT_WIDTH-1:0]);
          err_cnt++;
        end else begin
          want = y_expect_q.pop_front();
          if (m_tdata[OUT_WIDTH-1:0] !== want) begin
            $error("y: expected %0d, actual %0d", want, m_tdata[OUT_WIDTH-1:0]);
            err_cnt++;
          end
        end
      end
      m_tready <= !want_idle();
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL sigmoid_and_derivative_unit");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------
  initial begin
    logic [IN_WIDTH-1:0] edge_x[10];
    sample_t             item;
    // zero (exact half), both extremes, smallest steps, +-1.0, alternating bits
    edge_x[0] = '0;
    edge_x[1] = {1'b0, {(IN_WIDTH-1){1'b1}}};
    edge_x[2] = {1'b1, {(IN_WIDTH-1){1'b0}}};
    edge_x[3] = IN_WIDTH'(1);
    edge_x[4] = {IN_WIDTH{1'b1}};
    edge_x[5] = IN_WIDTH'(1) << IN_FRAC_BITS;
    edge_x[6] = -(IN_WIDTH'(1) << IN_FRAC_BITS);
    edge_x[7] = IN_WIDTH'(12'h555);
    edge_x[8] = IN_WIDTH'(12'hAAA);
    edge_x[9] = {1'b1, {(IN_WIDTH-1){1'b0}}} + IN_WIDTH'(1);
    for (int i = 0; i < 10; i++) begin
      item.fn = FN_SIGMOID;
      item.x  = edge_x[i];
      sample_q.push_back(item);
      item.fn = FN_DERIV;
      sample_q.push_back(item);
    end
    for (int i = 0; i < RAND_ITEMS; i++) begin
      item.fn = fn_t'($urandom_range(1));
      if ($urandom_range(3) == 0) begin
        // dense coverage of the steep region around zero
        item.x = IN_WIDTH'($urandom_range(1023) - 512);
      end else begin
        item.x = IN_WIDTH'($urandom);
      end
      sample_q.push_back(item);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (sample_q.size() != 0 || s_tvalid) @(negedge clk);
    while (y_expect_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_cnt == 0) begin
      $display("PASS sigmoid_and_derivative_unit");
    end else begin
      $display("FAIL sigmoid_and_derivative_unit");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/sigd_pkg.sv
design/sigd_abs.sv
design/sigd_rom.sv
design/sigd_post.sv
design/sigmoid_and_derivative_unit.sv
verif/tb.sv
